// ===== hw/rtl/trp_pkg.sv =====
// Shared types and constants for the trajectory record and playback block.
package trp_pkg;

    // Request codes carried in the input tuser field.
    typedef enum logic [1:0] {
        REQ_RESTART = 2'd0,
        REQ_RECORD  = 2'd1,
        REQ_PLAY    = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACTIVE   = 2'd0;
    localparam logic [1:0] CFG_DURATION = 2'd1;
    localparam logic [1:0] CFG_COEF     = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [31:0] DURATION_RESET = 32'd5000;
    localparam logic [15:0] COEF_RESET     = 16'd52429;

    // Long division of {time, 16 zero bits} by the duration, one bit a step.
    localparam logic [5:0] DIV_STEPS = 6'd48;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_RDA,
        ST_RDB,
        ST_RDC,
        ST_MIXX,
        ST_MIXY,
        ST_MIXE,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic rd_a;
        logic rd_b;
        logic rd_c;
        logic mix_x;
        logic mix_y;
        logic mix_e;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic empty;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/trp_ctrl.sv =====
// Controller state machine that sequences each accepted word through the datapath.
module trp_ctrl
    import trp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_req  i_req,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_req)
                        REQ_RECORD: n_state = ST_MIXX;
                        REQ_PLAY:   n_state = ST_DIV;
                        default:    n_state = ST_OUT;
                    endcase
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_stat.empty ? ST_OUT : ST_RDA;
            end
            ST_RDA: begin
                o_cmd.rd_a = 1'b1;
                n_state    = ST_RDB;
            end
            ST_RDB: begin
                o_cmd.rd_b = 1'b1;
                n_state    = ST_RDC;
            end
            ST_RDC: begin
                o_cmd.rd_c = 1'b1;
                n_state    = ST_MIXX;
            end
            ST_MIXX: begin
                o_cmd.mix_x = 1'b1;
                n_state     = ST_MIXY;
            end
            ST_MIXY: begin
                o_cmd.mix_y = 1'b1;
                n_state     = ST_MIXE;
            end
            ST_MIXE: begin
                o_cmd.mix_e = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/trp_dpath.sv =====
// Datapath: point stores, serial divider, multiplier, mixer and output register.
module trp_dpath
    import trp_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    parameter int COORD_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_addr,
    input  logic [31:0]           i_cfg_wdata,
    input  t_req                  i_req,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic [31:0]           i_play_time,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [COORD_BITS-1:0] o_out_x,
    output logic [COORD_BITS-1:0] o_out_y,
    output logic [10:0]           o_point_count,
    output logic                  o_position_event,
    output logic                  o_store_full
);

    localparam int CB = COORD_BITS;
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int PW = CB + 18;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
    localparam logic [PW-1:0] HALF_C  = PW'(32768);

    // Configuration registers.
    logic        r_active;
    logic [31:0] r_duration;
    logic [15:0] r_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_duration <= DURATION_RESET;
            r_coef     <= COEF_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ACTIVE:   r_active   <= i_cfg_wdata[0];
                CFG_DURATION: r_duration <= i_cfg_wdata;
                CFG_COEF:     r_coef     <= i_cfg_wdata[15:0];
                default:      ;
            endcase
        end
    end

    // Block state.
    logic [CW-1:0] r_count;
    logic [CB-1:0] r_sm_x, r_sm_y, r_cur_x, r_cur_y;

    // Work registers for one word.
    t_req          r_req;
    logic [CB-1:0] r_pa_x, r_pa_y, r_pb_x, r_pb_y;
    logic [16:0]   r_w;
    logic [47:0]   r_dvd;
    logic [31:0]   r_rem;
    logic [5:0]    r_div_cnt;
    logic [15+CW:0] r_delta;
    logic          r_last;
    logic [AW-1:0] r_idx;
    logic [PW-1:0] r_prod;
    logic [CB-1:0] r_mx, r_my;

    // Output register.
    logic          r_ov;
    logic [CB-1:0] r_ox, r_oy;
    logic [10:0]   r_ocnt;
    logic          r_oev, r_ofull;

    // Point stores.
    logic [CB-1:0] r_mem_x [STORE_DEPTH];
    logic [CB-1:0] r_mem_y [STORE_DEPTH];
    logic [CB-1:0] r_rd_x, r_rd_y;

    // Divider step: shift in one dividend bit, subtract the divisor if it fits.
    logic [31:0] div_d;
    logic [32:0] rem_sh;
    logic        rem_ge;
    assign div_d  = (r_duration == 32'd0) ? 32'd1 : r_duration;
    assign rem_sh = {r_rem, r_dvd[47]};
    assign rem_ge = rem_sh >= {1'b0, div_d};

    // Index selection for playback reads.
    logic [CW-1:0] idx_full, cnt_m1;
    logic [CW:0]   idx_p1;
    logic          last;
    logic [AW-1:0] addr_a, addr_b, rd_addr;
    assign idx_full = r_delta[16 +: CW];
    assign idx_p1   = {1'b0, idx_full} + {{CW{1'b0}}, 1'b1};
    assign cnt_m1   = r_count - {{(CW-1){1'b0}}, 1'b1};
    assign last     = idx_p1 >= {1'b0, r_count};
    assign addr_a   = last ? cnt_m1[AW-1:0] : idx_full[AW-1:0];
    assign addr_b   = r_last ? r_idx : AW'(r_idx + {{(AW-1){1'b0}}, 1'b1});
    assign rd_addr  = i_cmd.rd_a ? addr_a : addr_b;

    // Mixer: a + ((b - a) * w + half) >> 16, one coordinate a cycle.
    logic signed [CB:0]   diff_x, diff_y, diff_sel;
    logic signed [PW-1:0] prod;
    logic [PW-1:0]        rnd;
    logic [CB-1:0]        pa_sel, mix_res;
    assign diff_x   = $signed({1'b0, r_pb_x}) - $signed({1'b0, r_pa_x});
    assign diff_y   = $signed({1'b0, r_pb_y}) - $signed({1'b0, r_pa_y});
    assign diff_sel = i_cmd.mix_x ? diff_x : diff_y;
    assign prod     = PW'(diff_sel * $signed({1'b0, r_w}));
    assign rnd      = PW'($signed(r_prod + HALF_C) >>> 16);
    assign pa_sel   = i_cmd.mix_y ? r_pa_x : r_pa_y;
    assign mix_res  = CB'(rnd + {{(PW-CB){1'b0}}, pa_sel});

    // Results of a finished word.
    logic          store_room;
    logic [CW-1:0] n_count;
    logic [CB-1:0] n_ox, n_oy;
    logic          n_ev, n_full;
    logic [CW+10:0] cnt_ext;
    assign store_room = r_count < DEPTH_C;

    always_comb begin
        n_count = r_count;
        n_ox    = r_cur_x;
        n_oy    = r_cur_y;
        n_ev    = 1'b0;
        n_full  = 1'b0;
        case (r_req)
            REQ_RESTART: begin
                n_count = {{(CW-1){1'b0}}, 1'b1};
                n_ox    = r_pa_x;
                n_oy    = r_pa_y;
            end
            REQ_RECORD: begin
                n_ox = r_mx;
                n_oy = r_my;
                if (store_room) begin
                    n_count = r_count + {{(CW-1){1'b0}}, 1'b1};
                end else begin
                    n_full = 1'b1;
                end
            end
            REQ_PLAY: begin
                n_ev = r_active;
                if (r_count != '0) begin
                    n_ox = r_mx;
                    n_oy = r_my;
                end
            end
            default: ;
        endcase
    end
    assign cnt_ext = {11'b0, n_count};

    // Store write and registered read.
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    assign mem_we = i_cmd.finish &&
                    ((r_req == REQ_RESTART) || (r_req == REQ_RECORD && store_room));
    assign mem_wa = (r_req == REQ_RESTART) ? '0 : r_count[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_x[mem_wa] <= n_ox;
            r_mem_y[mem_wa] <= n_oy;
        end
        r_rd_x <= r_mem_x[rd_addr];
        r_rd_y <= r_mem_y[rd_addr];
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req;
            r_pa_x    <= i_pos_x;
            r_pa_y    <= i_pos_y;
            r_pb_x    <= r_sm_x;
            r_pb_y    <= r_sm_y;
            r_w       <= {1'b0, r_coef};
            r_dvd     <= {i_play_time, 16'b0};
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem     <= rem_ge ? 32'(rem_sh - {1'b0, div_d}) : rem_sh[31:0];
            r_dvd     <= {r_dvd[46:0], rem_ge};
            r_div_cnt <= r_div_cnt + 6'd1;
        end
        if (i_cmd.mul) begin
            r_delta <= {{CW{1'b0}}, r_dvd[15:0]} * {16'b0, r_count};
        end
        if (i_cmd.rd_a) begin
            r_last <= last;
            r_idx  <= addr_a;
            r_w    <= last ? 17'd0 : {1'b0, r_delta[15:0]};
        end
        if (i_cmd.rd_b) begin
            r_pa_x <= r_rd_x;
            r_pa_y <= r_rd_y;
        end
        if (i_cmd.rd_c) begin
            r_pb_x <= r_rd_x;
            r_pb_y <= r_rd_y;
        end
        if (i_cmd.mix_x || i_cmd.mix_y) begin
            r_prod <= prod;
        end
        if (i_cmd.mix_y) begin
            r_mx <= mix_res;
        end
        if (i_cmd.mix_e) begin
            r_my <= mix_res;
        end
    end

    // Block state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sm_x  <= '0;
            r_sm_y  <= '0;
            r_cur_x <= CB'(1) << (CB - 1);
            r_cur_y <= CB'(1) << (CB - 1);
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_count <= n_count;
                r_ov    <= 1'b1;
                if (r_req == REQ_RESTART || r_req == REQ_RECORD) begin
                    r_sm_x <= n_ox;
                    r_sm_y <= n_oy;
                end
                if (r_req == REQ_PLAY) begin
                    r_cur_x <= n_ox;
                    r_cur_y <= n_oy;
                end
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_ox    <= n_ox;
            r_oy    <= n_oy;
            r_ocnt  <= cnt_ext[10:0];
            r_oev   <= n_ev;
            r_ofull <= n_full;
        end
    end

    assign o_stat.div_last  = r_div_cnt == DIV_STEPS - 6'd1;
    assign o_stat.empty     = r_count == '0;
    assign o_stat.out_free  = !r_ov || i_out_ready;
    assign o_out_valid      = r_ov;
    assign o_out_x          = r_ox;
    assign o_out_y          = r_oy;
    assign o_point_count    = r_ocnt;
    assign o_position_event = r_oev;
    assign o_store_full     = r_ofull;

    // The point count never passes the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C) else $error("point count beyond store depth");

    // A dropped point is only reported with a full store.
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ofull) |-> (r_count == DEPTH_C)) else $error("full flag without full store");

    // Playback reads only written entries.
    a_read_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_a |-> ({{(CW-AW){1'b0}}, addr_a} < r_count))
        else $error("playback read beyond stored points");

endmodule

// ===== hw/rtl/trajectory_record_and_playback.sv =====
// Top level of the trajectory record and playback block.
// Each input word is processed alone. Restart and idle requests go straight to the output
// register, a record request passes through the shared mixer (x then y), and a playback
// request runs the bit-serial divider, which forms the loop phase in 48 steps, before the
// point reads and interpolation (both skipped on an empty store). A new word is taken while
// the previous result still waits in the output register. Point stores are not cleared;
// only written entries are read.
module trajectory_record_and_playback
    import trp_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    parameter int COORD_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_addr,
    input  logic [31:0]         i_cfg_wdata,
    // Input stream.
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // tdata fields from bit 0: pos_x, pos_y, play_time.
    input  logic [((2*COORD_BITS+32+7)/8)*8-1:0] i_s_tdata,
    // tuser fields from bit 0: req_type.
    input  logic [1:0]          i_s_tuser,
    // Output stream.
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // tdata fields from bit 0: out_x, out_y, point_count.
    output logic [((2*COORD_BITS+11+7)/8)*8-1:0] o_m_tdata,
    // tuser fields from bit 0: position_event, store_full.
    output logic [1:0]          o_m_tuser
);

    localparam int OUT_W = ((2 * COORD_BITS + 11 + 7) / 8) * 8;
    localparam int CB    = COORD_BITS;

    t_cmd  cmd;
    t_stat stat;
    t_req  req;
    logic [CB-1:0] out_x, out_y;
    logic [10:0]   out_cnt;
    logic          out_ev, out_full;

    assign req = t_req'(i_s_tuser);

    // Controller.
    trp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_req   (req),
        .i_stat  (stat),
        .o_ready (o_s_tready),
        .o_cmd   (cmd)
    );

    // Datapath.
    trp_dpath #(
        .STORE_DEPTH (STORE_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_req            (req),
        .i_pos_x          (i_s_tdata[CB-1:0]),
        .i_pos_y          (i_s_tdata[2*CB-1:CB]),
        .i_play_time      (i_s_tdata[2*CB+31:2*CB]),
        .i_out_ready      (i_m_tready),
        .o_out_valid      (o_m_tvalid),
        .o_out_x          (out_x),
        .o_out_y          (out_y),
        .o_point_count    (out_cnt),
        .o_position_event (out_ev),
        .o_store_full     (out_full)
    );

    // Output word packing.
    assign o_m_tdata = OUT_W'({out_cnt, out_y, out_x});
    assign o_m_tuser = {out_full, out_ev};

endmodule

// ===== tb/sv/tb_trajectory_record_and_playback.sv =====
// Self-checking testbench for the trajectory record and playback block.
`timescale 1ns / 1ps

module tb_trajectory_record_and_playback;
    import trp_pkg::*;

    localparam int IN_W       = 64;
    localparam int OUT_W      = 48;
    localparam int DEPTH      = 1024;
    localparam int STALL_MAX  = 4000;
    localparam int SETTLE_CYC = 100;

    // One expected result word.
    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [10:0] count;
        logic        event_flag;
        logic        full_flag;
    } t_traj_out;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [1:0]       i_cfg_addr;
    logic [31:0]      i_cfg_wdata;
    logic             i_s_tvalid;
    logic             o_s_tready;
    // tdata fields from bit 0: pos_x, pos_y, play_time.
    logic [IN_W-1:0]  i_s_tdata;
    // tuser fields from bit 0: req_type.
    logic [1:0]       i_s_tuser;
    logic             o_m_tvalid;
    logic             i_m_tready;
    // tdata fields from bit 0: out_x, out_y, point_count.
    logic [OUT_W-1:0] o_m_tdata;
    // tuser fields from bit 0: position_event, store_full.
    logic [1:0]       o_m_tuser;

    trajectory_record_and_playback u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Mirror of the block's state and registers.
    logic [15:0] mdl_store_x [DEPTH];
    logic [15:0] mdl_store_y [DEPTH];
    int unsigned mdl_count;
    logic [15:0] mdl_smooth_x, mdl_smooth_y;
    logic [15:0] mdl_cur_x, mdl_cur_y;
    logic        mdl_active;
    logic [31:0] mdl_duration;
    logic [15:0] mdl_coef;

    t_traj_out   pending_words[$];
    int          src_idle_pct;
    int          snk_idle_pct;
    int          mismatches;
    int          words_sent;
    int          words_checked;
    int          full_drops;
    int          play_events;
    int          stall_cycles;

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Rounded Q0.16 blend of two coordinates, a*(1-w) + b*w.
    function automatic logic [15:0] blend_q16(logic [15:0] a, logic [15:0] b, logic [15:0] w);
        logic [63:0] acc;
        acc = 64'(a) * (64'd65536 - 64'(w)) + 64'(b) * 64'(w) + 64'd32768;
        return acc[31:16];
    endfunction

    // Compute the result of one request and advance the mirrored state.
    function automatic t_traj_out traj_predict(t_req req, logic [15:0] px, logic [15:0] py,
                                               logic [31:0] t);
        t_traj_out   r;
        logic [63:0] d, phase, delta;
        int unsigned idx;
        logic [15:0] frac;
        r.x = mdl_cur_x;
        r.y = mdl_cur_y;
        r.event_flag = 1'b0;
        r.full_flag = 1'b0;
        case (req)
            REQ_RESTART: begin
                mdl_store_x[0] = px;
                mdl_store_y[0] = py;
                mdl_count = 1;
                mdl_smooth_x = px;
                mdl_smooth_y = py;
                r.x = px;
                r.y = py;
            end
            REQ_RECORD: begin
                mdl_smooth_x = blend_q16(px, mdl_smooth_x, mdl_coef);
                mdl_smooth_y = blend_q16(py, mdl_smooth_y, mdl_coef);
                r.x = mdl_smooth_x;
                r.y = mdl_smooth_y;
                if (mdl_count < DEPTH) begin
                    mdl_store_x[mdl_count] = mdl_smooth_x;
                    mdl_store_y[mdl_count] = mdl_smooth_y;
                    mdl_count++;
                end else begin
                    r.full_flag = 1'b1;
                end
            end
            REQ_PLAY: begin
                d = (mdl_duration == 0) ? 64'd1 : 64'(mdl_duration);
                phase = ((64'(t) % d) << 16) / d;
                if (mdl_count > 0) begin
                    delta = phase * 64'(mdl_count);
                    idx = int'(delta >> 16);
                    frac = delta[15:0];
                    if (idx + 1 < mdl_count) begin
                        mdl_cur_x = blend_q16(mdl_store_x[idx], mdl_store_x[idx+1], frac);
                        mdl_cur_y = blend_q16(mdl_store_y[idx], mdl_store_y[idx+1], frac);
                    end else begin
                        mdl_cur_x = mdl_store_x[mdl_count-1];
                        mdl_cur_y = mdl_store_y[mdl_count-1];
                    end
                end
                r.x = mdl_cur_x;
                r.y = mdl_cur_y;
                r.event_flag = mdl_active;
            end
            default: begin
            end
        endcase
        r.count = 11'(mdl_count);
        return r;
    endfunction

    // Send one request word; the caller starts just after a rising edge.
    task automatic send_word(t_req req, logic [15:0] px, logic [15:0] py, logic [31:0] t);
        bit taken;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= req;
        i_s_tdata  <= {t, py, px};
        do begin
            @(negedge i_clk);
            taken = i_s_tvalid && o_s_tready;
            @(posedge i_clk);
        end while (!taken);
        pending_words.push_back(traj_predict(req, px, py, t));
        words_sent++;
    endtask

    // Drop valid, let all outstanding results arrive, then settle.
    task automatic drain_block();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Write one configuration register; the block must be idle.
    task automatic write_reg(logic [1:0] addr, logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            CFG_ACTIVE:   mdl_active = value[0];
            CFG_DURATION: mdl_duration = value;
            CFG_COEF:     mdl_coef = value[15:0];
            default: begin
            end
        endcase
    endtask

    // Result checker and stall watchdog, sampled at the falling edge.
    always @(negedge i_clk) begin
        t_traj_out exp_w;
        logic      got_out;
        got_out = i_rst_n && o_m_tvalid && i_m_tready;
        if (got_out || (i_s_tvalid && o_s_tready) || !i_rst_n) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_MAX) begin
                $display("Timeout: no word moved for %0d cycles.", STALL_MAX);
                $display("FAILURE");
                $finish;
            end
        end
        if (got_out) begin
            words_checked++;
            if (o_m_tuser[0]) play_events++;
            if (o_m_tuser[1]) full_drops++;
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result word %h/%h", o_m_tdata, o_m_tuser);
            end else begin
                exp_w = pending_words.pop_front();
                if (o_m_tdata[15:0] !== exp_w.x || o_m_tdata[31:16] !== exp_w.y ||
                    o_m_tdata[42:32] !== exp_w.count || o_m_tdata[47:43] !== 5'd0 ||
                    o_m_tuser[0] !== exp_w.event_flag || o_m_tuser[1] !== exp_w.full_flag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: exp x=%h y=%h n=%0d ev=%b full=%b, got x=%h y=%h n=%0d ev=%b full=%b",
                                 exp_w.x, exp_w.y, exp_w.count, exp_w.event_flag,
                                 exp_w.full_flag, o_m_tdata[15:0], o_m_tdata[31:16],
                                 o_m_tdata[42:32], o_m_tuser[0], o_m_tuser[1]);
                end
            end
        end
    end

    // Output backpressure.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Playback on an empty store, idle requests and field extremes.
    task automatic test_edges();
        send_word(REQ_PLAY, 16'h0, 16'h0, 32'd1234);
        send_word(REQ_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(REQ_RESTART, 16'h0000, 16'hFFFF, 32'h0);
        send_word(REQ_RECORD, 16'hFFFF, 16'h0000, 32'h0);
        send_word(REQ_RECORD, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
        send_word(REQ_RESTART, 16'hFFFF, 16'h0000, 32'h0);
        send_word(REQ_RECORD, 16'h0000, 16'hFFFF, 32'h0);
        send_word(REQ_RECORD, 16'h1234, 16'h8000, 32'h0);
        send_word(REQ_PLAY, 16'h0, 16'h0, 32'd0);
        send_word(REQ_PLAY, 16'h0, 16'h0, 32'd2500);
        send_word(REQ_PLAY, 16'h0, 16'h0, 32'd4999);
        send_word(REQ_PLAY, 16'h0, 16'h0, 32'hFFFF_FFFF);
        send_word(REQ_NONE, 16'h0, 16'h0, 32'h0);
        drain_block();
    endtask

    // Register extremes: smoother weights, zero and maximum durations, events.
    task automatic test_config_extremes();
        write_reg(CFG_ACTIVE, 32'd1);
        write_reg(CFG_COEF, 32'd0);
        send_word(REQ_RESTART, 16'h0100, 16'h0200, 32'h0);
        send_word(REQ_RECORD, 16'hABCD, 16'h1357, 32'h0);
        drain_block();
        write_reg(CFG_COEF, 32'h0000_FFFF);
        write_reg(CFG_DURATION, 32'd0);
        send_word(REQ_RECORD, 16'hFFFF, 16'hFFFF, 32'h0);
        send_word(REQ_PLAY, 16'h0, 16'h0, 32'd777);
        drain_block();
        write_reg(CFG_DURATION, 32'hFFFF_FFFF);
        send_word(REQ_PLAY, 16'h0, 16'h0, 32'hFFFF_FFFE);
        send_word(REQ_PLAY, 16'h0, 16'h0, 32'h8000_0000);
        drain_block();
        write_reg(CFG_DURATION, 32'd1);
        send_word(REQ_PLAY, 16'h0, 16'h0, 32'd5);
        drain_block();
    endtask

    // Fill the store past its depth, then play back near the loop end and at random times.
    task automatic test_store_full();
        write_reg(CFG_COEF, 32'd30000);
        write_reg(CFG_DURATION, 32'd100000);
        send_word(REQ_RESTART, 16'($urandom), 16'($urandom), 32'h0);
        repeat (DEPTH + 3)
            send_word(REQ_RECORD, 16'($urandom), 16'($urandom), 32'($urandom));
        send_word(REQ_PLAY, 16'h0, 16'h0, 32'd99999);
        repeat (6) send_word(REQ_PLAY, 16'h0, 16'h0, 32'($urandom));
        drain_block();
    endtask

    // Random mix of record and playback requests, with some restarts and idle requests as noise.
    task automatic test_random_sessions(int n_words);
        int          roll;
        logic [31:0] dur;
        for (int i = 0; i < n_words; i++) begin
            roll = $urandom_range(99);
            if (roll < 6)
                send_word(REQ_RESTART, 16'($urandom), 16'($urandom), 32'($urandom));
            else if (roll < 50)
                send_word(REQ_RECORD, 16'($urandom), 16'($urandom), 32'($urandom));
            else if (roll < 95)
                send_word(REQ_PLAY, 16'($urandom), 16'($urandom),
                          ($urandom_range(1)) ? 32'($urandom) :
                          32'($urandom_range(mdl_duration)));
            else
                send_word(REQ_NONE, 16'($urandom), 16'($urandom), 32'($urandom));
        end
        drain_block();
        // New settings for the next phase.
        write_reg(CFG_ACTIVE, 32'($urandom_range(1)));
        write_reg(CFG_COEF, $urandom);
        dur = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(20000, 1));
        write_reg(CFG_DURATION, dur);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = CFG_ACTIVE;
        i_cfg_wdata = 32'h0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = REQ_NONE;
        i_m_tready  = 1'b0;
        src_idle_pct = 27;
        snk_idle_pct = 74;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        full_drops = 0;
        play_events = 0;
        stall_cycles = 0;
        mdl_count = 0;
        mdl_smooth_x = 16'h0;
        mdl_smooth_y = 16'h0;
        mdl_cur_x = 16'h8000;
        mdl_cur_y = 16'h8000;
        mdl_active = 1'b0;
        mdl_duration = DURATION_RESET;
        mdl_coef = COEF_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edges();
        test_config_extremes();
        test_random_sessions(220);
        src_idle_pct = 74;
        snk_idle_pct = 27;
        test_store_full();
        test_random_sessions(220);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_sessions(220);

        $display("Covered %0d request words and %0d results: %0d playback events, %0d drops.",
                 words_sent, words_checked, play_events, full_drops);
        $display("Phases ran with source and sink stalls, register extremes and a full store.");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatching results.", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
